// File: hdl/wcc_pkg.sv
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared status codes and types for the weighted circumcenter pipeline.
// ----------------------------------------------------------------------------
package wcc_pkg;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_DEGEN = 2'd1;
    localparam t_status STAT_SAT   = 2'd2;

endpackage

// File: hdl/weighted_circumcenter_2d.sv
// ----------------------------------------------------------------------------
// weighted_circumcenter_2d
// Power center of triangle (x, a, b) with weighted vertices a and b.
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_stall | i_center_*, i_first_*, i_second_*
//  output  | o_valid | i_stall | o_result_x, o_result_y, o_status
//
//  One item per cycle while the output is not stalled. The pipe has five arithmetic
//  stages, a sign/magnitude stage, one restoring divider stage per quotient
//  bit (COORD_WIDTH + 1 of them), then the clamp/output register.
//  The whole pipe holds while a result waits and i_stall is high.
//  Reset (synchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
module weighted_circumcenter_2d
    import wcc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_weight,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_weight,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_result_x,
    output logic signed [COORD_WIDTH-1:0] o_result_y,
    output t_status                       o_status
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = W + 1;                 // coordinate difference
    localparam int H   = (DW + 1) / 2;          // low split of a difference
    localparam int HH  = DW - H;
    localparam int PW  = 2 * DW;                // difference product
    localparam int AW  = ((2 * W + 2 > W + F) ? 2 * W + 2 : W + F) + 2;
    localparam int CW  = 2 * W + 2;             // cross product
    localparam int K   = AW / 2;                // low split of A, B
    localparam int AHW = AW - K;
    localparam int FW  = AW + DW;               // A * d
    localparam int NW  = FW + 1;                // numerator
    localparam int QB  = W + 1;                 // quotient bits kept
    localparam int MW  = (NW > CW + 1 + QB) ? NW : CW + 1 + QB;
    localparam int NS  = 6 + QB;                // stages before output reg

    function automatic logic signed [DW+H:0] mul_dlo(input logic signed [DW-1:0] a,
                                                     input logic [H-1:0] b);
        mul_dlo = a * $signed({1'b0, b});
    endfunction

    function automatic logic signed [DW+HH-1:0] mul_dhi(input logic signed [DW-1:0] a,
                                                        input logic signed [HH-1:0] b);
        mul_dhi = a * b;
    endfunction

    function automatic logic signed [K+DW:0] mul_alo(input logic [K-1:0] a,
                                                     input logic signed [DW-1:0] d);
        mul_alo = $signed({1'b0, a}) * d;
    endfunction

    function automatic logic signed [AHW+DW-1:0] mul_ahi(input logic signed [AHW-1:0] a,
                                                         input logic signed [DW-1:0] d);
        mul_ahi = a * d;
    endfunction

    logic          en;
    logic [NS-1:0] r_v;
    logic          r_ov;

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    // stage 0: differences
    logic signed [DW-1:0] r0_dax, r0_day, r0_dbx, r0_dby;
    logic signed [W-1:0]  r0_wa, r0_wb, r0_cx, r0_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_dax <= DW'(i_first_x) - DW'(i_center_x);
            r0_day <= DW'(i_first_y) - DW'(i_center_y);
            r0_dbx <= DW'(i_second_x) - DW'(i_center_x);
            r0_dby <= DW'(i_second_y) - DW'(i_center_y);
            r0_wa  <= i_first_weight;
            r0_wb  <= i_second_weight;
            r0_cx  <= i_center_x;
            r0_cy  <= i_center_y;
        end
    end

    // stage 1: partial products of squares and cross terms
    // index: 0 dax^2, 1 day^2, 2 dbx^2, 3 dby^2, 4 dax*dby, 5 day*dbx
    logic signed [DW+H:0]    r1_pl [6];
    logic signed [DW+HH-1:0] r1_ph [6];
    logic signed [DW-1:0]    r1_dax, r1_day, r1_dbx, r1_dby;
    logic signed [W-1:0]     r1_wa, r1_wb, r1_cx, r1_cy;
    logic signed [DW-1:0]    s1_a [6];
    logic signed [DW-1:0]    s1_b [6];

    always_comb begin
        s1_a[0] = r0_dax; s1_b[0] = r0_dax;
        s1_a[1] = r0_day; s1_b[1] = r0_day;
        s1_a[2] = r0_dbx; s1_b[2] = r0_dbx;
        s1_a[3] = r0_dby; s1_b[3] = r0_dby;
        s1_a[4] = r0_dax; s1_b[4] = r0_dby;
        s1_a[5] = r0_day; s1_b[5] = r0_dbx;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r1_pl[k] <= mul_dlo(s1_a[k], s1_b[k][H-1:0]);
                r1_ph[k] <= mul_dhi(s1_a[k], s1_b[k][DW-1:H]);
            end
            r1_dax <= r0_dax; r1_day <= r0_day;
            r1_dbx <= r0_dbx; r1_dby <= r0_dby;
            r1_wa  <= r0_wa;  r1_wb  <= r0_wb;
            r1_cx  <= r0_cx;  r1_cy  <= r0_cy;
        end
    end

    // stage 2: A, B and cross
    logic signed [PW-1:0] s2_p [6];
    logic signed [AW-1:0] r2_a, r2_b;
    logic signed [CW-1:0] r2_cross;
    logic signed [DW-1:0] r2_dax, r2_day, r2_dbx, r2_dby;
    logic signed [W-1:0]  r2_cx, r2_cy;

    always_comb begin
        for (int k = 0; k < 6; k++)
            s2_p[k] = (PW'(r1_ph[k]) <<< H) + PW'(r1_pl[k]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a     <= AW'(s2_p[0]) + AW'(s2_p[1]) - (AW'(r1_wa) <<< F);
            r2_b     <= AW'(s2_p[2]) + AW'(s2_p[3]) - (AW'(r1_wb) <<< F);
            r2_cross <= CW'(s2_p[4]) - CW'(s2_p[5]);
            r2_dax <= r1_dax; r2_day <= r1_day;
            r2_dbx <= r1_dbx; r2_dby <= r1_dby;
            r2_cx  <= r1_cx;  r2_cy  <= r1_cy;
        end
    end

    // stage 3: numerator partial products
    // index: 0 A*dby, 1 B*day, 2 B*dax, 3 A*dbx
    logic signed [K+DW:0]     r3_nl [4];
    logic signed [AHW+DW-1:0] r3_nh [4];
    logic signed [AW-1:0]     s3_m [4];
    logic signed [DW-1:0]     s3_d [4];
    logic signed [CW-1:0]     r3_cross;
    logic signed [W-1:0]      r3_cx, r3_cy;

    always_comb begin
        s3_m[0] = r2_a; s3_d[0] = r2_dby;
        s3_m[1] = r2_b; s3_d[1] = r2_day;
        s3_m[2] = r2_b; s3_d[2] = r2_dax;
        s3_m[3] = r2_a; s3_d[3] = r2_dbx;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r3_nl[k] <= mul_alo(s3_m[k][K-1:0], s3_d[k]);
                r3_nh[k] <= mul_ahi(s3_m[k][AW-1:K], s3_d[k]);
            end
            r3_cross <= r2_cross;
            r3_cx    <= r2_cx;
            r3_cy    <= r2_cy;
        end
    end

    // stage 4: numerators and denominator
    logic signed [FW-1:0] s4_f [4];
    logic signed [NW-1:0] r4_nx, r4_ny;
    logic signed [CW:0]   r4_den;
    logic                 r4_degen;
    logic signed [W-1:0]  r4_cx, r4_cy;

    always_comb begin
        for (int k = 0; k < 4; k++)
            s4_f[k] = (FW'(r3_nh[k]) <<< K) + FW'(r3_nl[k]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_nx    <= NW'(s4_f[0]) - NW'(s4_f[1]);
            r4_ny    <= NW'(s4_f[2]) - NW'(s4_f[3]);
            r4_den   <= (CW + 1)'(r3_cross) <<< 1;
            r4_degen <= (r3_cross == '0);
            r4_cx    <= r3_cx;
            r4_cy    <= r3_cy;
        end
    end

    // stage 5 (divider slot 0) and divider slots 1..QB
    logic [MW-1:0]       r_rem_x [QB+1];
    logic [MW-1:0]       r_rem_y [QB+1];
    logic [QB-1:0]       r_q_x   [QB+1];
    logic [QB-1:0]       r_q_y   [QB+1];
    logic [CW:0]         r_dmag  [QB+1];
    logic                r_neg_x [QB+1];
    logic                r_neg_y [QB+1];
    logic                r_big_x [QB+1];
    logic                r_big_y [QB+1];
    logic                r_degen [QB+1];
    logic signed [W-1:0] r_cx    [QB+1];
    logic signed [W-1:0] r_cy    [QB+1];

    logic [NW-1:0] s5_mx, s5_my;
    logic [CW:0]   s5_md;
    logic [MW-1:0] s5_lim;

    always_comb begin
        s5_mx  = r4_nx[NW-1] ? (~r4_nx + 1'b1) : r4_nx;
        s5_my  = r4_ny[NW-1] ? (~r4_ny + 1'b1) : r4_ny;
        s5_md  = r4_den[CW] ? (~r4_den + 1'b1) : r4_den;
        s5_lim = MW'(s5_md) << QB;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_x[0] <= MW'(s5_mx);
            r_rem_y[0] <= MW'(s5_my);
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_dmag[0]  <= s5_md;
            r_neg_x[0] <= r4_nx[NW-1] ^ r4_den[CW];
            r_neg_y[0] <= r4_ny[NW-1] ^ r4_den[CW];
            // quotient of 2^QB or more saturates whatever the center is
            r_big_x[0] <= (MW'(s5_mx) >= s5_lim);
            r_big_y[0] <= (MW'(s5_my) >= s5_lim);
            r_degen[0] <= r4_degen;
            r_cx[0]    <= r4_cx;
            r_cy[0]    <= r4_cy;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [MW-1:0] sh;
        logic          ge_x, ge_y;

        assign sh   = MW'(r_dmag[j-1]) << (QB - j);
        assign ge_x = (r_rem_x[j-1] >= sh);
        assign ge_y = (r_rem_y[j-1] >= sh);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem_x[j] <= ge_x ? r_rem_x[j-1] - sh : r_rem_x[j-1];
                r_rem_y[j] <= ge_y ? r_rem_y[j-1] - sh : r_rem_y[j-1];
                r_q_x[j]   <= r_q_x[j-1] | (QB'(ge_x) << (QB - j));
                r_q_y[j]   <= r_q_y[j-1] | (QB'(ge_y) << (QB - j));
                r_dmag[j]  <= r_dmag[j-1];
                r_neg_x[j] <= r_neg_x[j-1];
                r_neg_y[j] <= r_neg_y[j-1];
                r_big_x[j] <= r_big_x[j-1];
                r_big_y[j] <= r_big_y[j-1];
                r_degen[j] <= r_degen[j-1];
                r_cx[j]    <= r_cx[j-1];
                r_cy[j]    <= r_cy[j-1];
            end
        end
    end

    // output stage: sign, add center, clamp
    logic signed [W+2:0] s_sum_x, s_sum_y, s_max, s_min;
    logic signed [W-1:0] s_res_x, s_res_y;
    logic                s_sat_x, s_sat_y;

    always_comb begin
        s_max   = {4'b0000, {(W-1){1'b1}}};
        s_min   = {4'b1111, {(W-1){1'b0}}};
        s_sum_x = (W + 3)'(r_cx[QB]) + (r_neg_x[QB] ? -(W + 3)'(r_q_x[QB])
                                                    : (W + 3)'(r_q_x[QB]));
        s_sum_y = (W + 3)'(r_cy[QB]) + (r_neg_y[QB] ? -(W + 3)'(r_q_y[QB])
                                                    : (W + 3)'(r_q_y[QB]));
        s_sat_x = 1'b1;
        s_sat_y = 1'b1;
        if (r_big_x[QB])
            s_res_x = r_neg_x[QB] ? W'(s_min) : W'(s_max);
        else if (s_sum_x > s_max)
            s_res_x = W'(s_max);
        else if (s_sum_x < s_min)
            s_res_x = W'(s_min);
        else begin
            s_res_x = W'(s_sum_x);
            s_sat_x = 1'b0;
        end
        if (r_big_y[QB])
            s_res_y = r_neg_y[QB] ? W'(s_min) : W'(s_max);
        else if (s_sum_y > s_max)
            s_res_y = W'(s_max);
        else if (s_sum_y < s_min)
            s_res_y = W'(s_min);
        else begin
            s_res_y = W'(s_sum_y);
            s_sat_y = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_degen[QB]) begin
                o_result_x <= '0;
                o_result_y <= '0;
                o_status   <= STAT_DEGEN;
            end else begin
                o_result_x <= s_res_x;
                o_result_y <= s_res_y;
                o_status   <= (s_sat_x || s_sat_y) ? STAT_SAT : STAT_OK;
            end
        end
    end

    // checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_DEGEN) |-> (o_result_x == '0 && o_result_y == '0))
        else $error("degenerate item with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_DEGEN
                     || o_status == STAT_SAT))
        else $error("undefined status code");

    a_stall_src: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// File: tb/tb_weighted_circumcenter_2d.sv
// ----------------------------------------------------------------------------
// tb_weighted_circumcenter_2d
// Self-checking bench for the weighted circumcenter pipeline. Each accepted
// item is predicted with wide exact integer math and queued. Results are
// checked in order, with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_circumcenter_2d;
    import wcc_pkg::*;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = 6 + CW + 1;
    localparam int WD_LIMIT = 5000;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [159:0]   t_wide;

    typedef struct packed {
        t_coord  rx;
        t_coord  ry;
        t_status st;
    } t_center;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_coord  i_center_x, i_center_y;
    t_coord  i_first_x, i_first_y, i_first_weight;
    t_coord  i_second_x, i_second_y, i_second_weight;
    logic    o_valid;
    logic    i_stall;
    t_coord  o_result_x, o_result_y;
    t_status o_status;

    t_center center_q[$];
    int      fail_cnt;
    int      quiet_cycles;
    bit      busy_free;     // long stretch with no idling on either side

    weighted_circumcenter_2d #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_coord clamp_coord(input t_wide v, inout bit sat);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -(t_wide'(1) <<< (CW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic t_center power_center(
        input t_coord cx, cy, ax, ay, aw, bx, by, bw);
        t_wide   dax, day, dbx, dby, pa, pb, crs, den, nx, ny;
        bit      sat;
        t_center r;
        dax = t_wide'(ax) - t_wide'(cx);
        day = t_wide'(ay) - t_wide'(cy);
        dbx = t_wide'(bx) - t_wide'(cx);
        dby = t_wide'(by) - t_wide'(cy);
        pa  = dax * dax + day * day - (t_wide'(aw) <<< FB);
        pb  = dbx * dbx + dby * dby - (t_wide'(bw) <<< FB);
        crs = dax * dby - day * dbx;
        sat = 1'b0;
        if (crs == 0) begin
            r.rx = '0;
            r.ry = '0;
            r.st = STAT_DEGEN;
            return r;
        end
        den  = crs + crs;
        nx   = pa * dby - pb * day;
        ny   = pb * dax - pa * dbx;
        // signed division truncates toward zero
        r.rx = clamp_coord(t_wide'(cx) + nx / den, sat);
        r.ry = clamp_coord(t_wide'(cy) + ny / den, sat);
        r.st = sat ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    // predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            center_q.push_back(power_center(i_center_x, i_center_y, i_first_x,
                i_first_y, i_first_weight, i_second_x, i_second_y,
                i_second_weight));
    end

    always @(posedge i_clk) begin
        t_center want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (center_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h st=%0d", $time,
                    o_result_x, o_result_y, o_status);
                fail_cnt++;
            end else begin
                want = center_q.pop_front();
                if (o_result_x !== want.rx) begin
                    $display("%0t: result_x expected %h actual %h", $time,
                        want.rx, o_result_x);
                    fail_cnt++;
                end
                if (o_result_y !== want.ry) begin
                    $display("%0t: result_y expected %h actual %h", $time,
                        want.ry, o_result_y);
                    fail_cnt++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                        want.st, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (!busy_free && $urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("weighted_circumcenter_2d test failed");
            $finish;
        end
    end

    task automatic send_item(input t_coord cx, cy, ax, ay, aw, bx, by, bw);
        while (!busy_free && $urandom_range(99) < 27) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_center_x = cx;  i_center_y = cy;
        i_first_x  = ax;  i_first_y  = ay;  i_first_weight  = aw;
        i_second_x = bx;  i_second_y = by;  i_second_weight = bw;
        i_valid    = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (center_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_coord rnd_small();
        return t_coord'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    task automatic test_extremes();
        t_coord mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_item(0, 0, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0);
        send_item(mn, mn, mx, mn, mx, mn, mx, mn);
        send_item(mx, mx, mn, mx, mn, mx, mn, mx);
        send_item(mn, mx, mx, mx, 0, mn, mn, 0);
        send_item(0, 0, mx, 0, mn, 0, mx, mn);
        send_item(0, 0, mx, 0, mx, 0, mn, mx);
        send_item(1, 1, 2, 1, 0, 1, 2, 0);
        send_item(32'sh0003_0000, -32'sh0002_0000, 32'sh0010_0000, 32'sh0001_0000,
            32'sh0004_0000, -32'sh0007_0000, 32'sh0005_0000, -32'sh0002_0000);
    endtask

    task automatic test_degenerate();
        // collinear, coincident, and one vertex on the center
        send_item(0, 0, 32'sh0001_0000, 32'sh0001_0000, 5, 32'sh0002_0000,
            32'sh0002_0000, 7);
        send_item(7, 9, 7, 9, 3, 7, 9, 4);
        send_item(5, 5, 5, 5, 0, 32'sh0001_0000, 9, 1);
        send_item(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
        send_item(1, 2, 3, 2, 1, 32'sh7FFF_FFFF, 2, 1);
    endtask

    task automatic test_saturation();
        // nearly collinear or extreme weights: huge center
        send_item(0, 0, 32'sh0100_0000, 1, 0, 32'sh0200_0000, 3, 0);
        send_item(0, 0, 32'sh0100_0000, -1, 0, -32'sh0200_0000, -3, 0);
        send_item(32'sh7FFF_0000, 0, 32'sh7FFF_0001, 32'sh7000_0000, 0,
            32'sh7FFF_0002, 32'sh7000_0001, 0);
        send_item(0, 0, 1, 0, 32'sh7FFF_FFFF, 0, 1, 32'sh8000_0000);
    endtask

    task automatic test_random(input int n);
        t_coord cx, cy, ax, ay, aw, bx, by, bw;
        int     kind, k;
        for (int i = 0; i < n; i++) begin
            busy_free = (i >= n / 3 && i < n / 3 + 200);
            kind = $urandom_range(99);
            cx = rnd_small();  cy = rnd_small();
            ax = cx + rnd_small();  ay = cy + rnd_small();
            bx = cx + rnd_small();  by = cy + rnd_small();
            aw = rnd_small();  bw = rnd_small();
            if (kind < 15) begin
                cx = $urandom;  cy = $urandom;  ax = $urandom;  ay = $urandom;
                aw = $urandom;  bx = $urandom;  by = $urandom;  bw = $urandom;
            end else if (kind < 25) begin
                k  = $signed($urandom_range(8)) - 4;
                bx = cx + k * (ax - cx);
                by = cy + k * (ay - cy);
            end else if (kind < 32) begin
                bx = cx + 2 * (ax - cx) + $signed($urandom_range(2)) - 1;
                by = cy + 2 * (ay - cy);
            end
            send_item(cx, cy, ax, ay, aw, bx, by, bw);
        end
        busy_free = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_drained();
        test_random(20);
    endtask

    initial begin
        fail_cnt        = 0;
        quiet_cycles    = 0;
        busy_free       = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_center_x      = '0;  i_center_y = '0;
        i_first_x       = '0;  i_first_y  = '0;  i_first_weight  = '0;
        i_second_x      = '0;  i_second_y = '0;  i_second_weight = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_degenerate();
        test_saturation();
        test_drain_pause();
        test_random(1280);

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_cnt == 0 && center_q.size() == 0)
            $display("weighted_circumcenter_2d test passed");
        else
            $display("weighted_circumcenter_2d test failed");
        $finish;
    end

endmodule
